// ----- rtl/core/stm_pkg.sv -----
package stm_pkg;

  // Command codes carried on the action field
  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_MOVE    = 2'd1,
    ACT_NUDGE   = 2'd2,
    ACT_SET_POS = 2'd3
  } action_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_NEUTRAL = 2'd0;
  localparam logic [1:0] CFG_MIN     = 2'd1;
  localparam logic [1:0] CFG_MAX     = 2'd2;

  // Sequencer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_MOVING    = 5'b00010,
    PH_CENTERING = 5'b00100,
    PH_NUDGE_OUT = 5'b01000,
    PH_NUDGE_IN  = 5'b10000
  } phase_t;

  // Phase codes as seen on the result channel
  localparam logic [2:0] PHC_IDLE      = 3'd0;
  localparam logic [2:0] PHC_MOVING    = 3'd1;
  localparam logic [2:0] PHC_CENTERING = 3'd2;
  localparam logic [2:0] PHC_NUDGE_OUT = 3'd3;
  localparam logic [2:0] PHC_NUDGE_IN  = 3'd4;

  // Timing in millisecond ticks
  localparam logic [15:0] MOVE_MIN_MS  = 16'd10;
  localparam logic [15:0] MOVE_MAX_MS  = 16'd5000;
  localparam logic [12:0] CENTER_MS    = 13'd50;
  localparam logic [12:0] NUDGE_OUT_MS = 13'd80;
  localparam logic [12:0] NUDGE_IN_MS  = 13'd40;

  localparam logic signed [13:0] NUDGE_OFFSET_US = 14'sd400;

  // Register reset values
  localparam logic [11:0] NEUTRAL_RST = 12'd1500;
  localparam logic [11:0] MIN_RST     = 12'd1000;
  localparam logic [11:0] MAX_RST     = 12'd2000;

  typedef struct packed {
    phase_t      phase;
    logic [12:0] remaining;
    logic [11:0] pulse;
    logic        drive;
  } seq_state_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic        drive_on;
    logic [2:0]  phase;
    logic        stopped;
  } result_t;

  typedef struct packed {
    logic [11:0] neutral;
    logic [11:0] min_pulse;
    logic [11:0] max_pulse;
  } cfg_t;

  // Raise to min, then cap at max: max wins when min > max
  function automatic logic [11:0] clamp_pulse(logic signed [13:0] v, logic [11:0] lo,
                                              logic [11:0] hi);
    logic signed [13:0] t;
    t = v;
    if (t < $signed({2'b00, lo})) t = $signed({2'b00, lo});
    if (t > $signed({2'b00, hi})) t = $signed({2'b00, hi});
    return t[11:0];
  endfunction

  function automatic logic [2:0] phase_code(phase_t p);
    case (p)
      PH_MOVING:    return PHC_MOVING;
      PH_CENTERING: return PHC_CENTERING;
      PH_NUDGE_OUT: return PHC_NUDGE_OUT;
      PH_NUDGE_IN:  return PHC_NUDGE_IN;
      default:      return PHC_IDLE;
    endcase
  endfunction

endpackage

// ----- rtl/core/stm_step.sv -----
module stm_step
  import stm_pkg::*;
(
  input  cfg_t        cfg,
  input  seq_state_t  cur,
  input  logic [1:0]  action,
  input  logic        up,
  input  logic [15:0] duration_ms,
  input  logic [11:0] position_us,
  output seq_state_t  nxt,
  output result_t     res
);

  logic [11:0]        neutral_c;
  logic signed [13:0] neutral_s;
  logic signed [13:0] nudge_s;
  logic [15:0]        dur_c;
  logic               stop;

  // Shared clamped values
  always_comb begin
    neutral_c = clamp_pulse($signed({2'b00, cfg.neutral}), cfg.min_pulse, cfg.max_pulse);
    neutral_s = $signed({2'b00, neutral_c});
    nudge_s   = up ? (neutral_s + NUDGE_OFFSET_US) : (neutral_s - NUDGE_OFFSET_US);
    dur_c     = duration_ms;
    if (dur_c < MOVE_MIN_MS) dur_c = MOVE_MIN_MS;
    if (dur_c > MOVE_MAX_MS) dur_c = MOVE_MAX_MS;
  end

  // Command decode and tick countdown
  always_comb begin
    nxt  = cur;
    stop = 1'b0;
    case (action_t'(action))
      ACT_TICK: begin
        case (cur.phase)
          PH_MOVING, PH_CENTERING, PH_NUDGE_OUT, PH_NUDGE_IN: begin
            if (cur.remaining > 13'd1) begin
              nxt.remaining = cur.remaining - 13'd1;
            end else if (cur.phase == PH_MOVING) begin
              nxt.pulse     = neutral_c;
              nxt.remaining = CENTER_MS;
              nxt.phase     = PH_CENTERING;
            end else if (cur.phase == PH_NUDGE_OUT) begin
              nxt.pulse     = neutral_c;
              nxt.remaining = NUDGE_IN_MS;
              nxt.phase     = PH_NUDGE_IN;
            end else begin
              nxt.drive     = 1'b0;
              nxt.remaining = '0;
              nxt.phase     = PH_IDLE;
              stop          = 1'b1;
            end
          end
          default: begin
            nxt.phase = PH_IDLE;
          end
        endcase
      end
      ACT_MOVE: begin
        nxt.drive     = 1'b1;
        nxt.pulse     = clamp_pulse($signed({2'b00, up ? cfg.max_pulse : cfg.min_pulse}),
                                    cfg.min_pulse, cfg.max_pulse);
        nxt.remaining = dur_c[12:0];
        nxt.phase     = PH_MOVING;
      end
      ACT_NUDGE: begin
        nxt.drive     = 1'b1;
        nxt.pulse     = clamp_pulse(nudge_s, cfg.min_pulse, cfg.max_pulse);
        nxt.remaining = NUDGE_OUT_MS;
        nxt.phase     = PH_NUDGE_OUT;
      end
      default: begin
        nxt.drive     = 1'b1;
        nxt.pulse     = clamp_pulse($signed({2'b00, position_us}), cfg.min_pulse,
                                    cfg.max_pulse);
        nxt.remaining = '0;
        nxt.phase     = PH_IDLE;
      end
    endcase
  end

  // Result view of the updated state
  always_comb begin
    res.pulse_us = clamp_pulse($signed({2'b00, nxt.pulse}), cfg.min_pulse, cfg.max_pulse);
    res.drive_on = nxt.drive;
    res.phase    = phase_code(nxt.phase);
    res.stopped  = stop;
  end

endmodule

// ----- rtl/core/servo_tilt_move_sequencer.sv -----
// Servo tilt move sequencer. Each input transaction (a 1 ms tick, a timed
// move, a nudge or a direct position) yields exactly one result transaction
// with the clamped pulse width, drive enable, phase and stop flag. Items are
// captured in an input register and resolved by one pass of clamp, compare
// and decrement logic into the result register, so one item per clock is
// sustained while out_ready stays high; a low out_ready holds the items. Write
// configuration registers (neutral, min, max pulse width) only while no
// transaction is in flight; the output clamp always uses the current values.
module servo_tilt_move_sequencer
  import stm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_up,
  input  logic [15:0] in_duration_ms,
  input  logic [11:0] in_position_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_pulse_us,
  output logic        out_drive_on,
  output logic [2:0]  out_phase,
  output logic        out_stopped,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  cfg_t        cfg_r;
  seq_state_t  st_r;
  seq_state_t  st_nxt;
  result_t     res_nxt;
  result_t     res_r;
  logic        in_vld_r;
  logic [1:0]  act_r;
  logic        up_r;
  logic [15:0] dur_r;
  logic [11:0] pos_r;
  logic        out_vld_r;
  logic        advance;

  // Item moves to the result register when that slot is free or draining
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral   <= NEUTRAL_RST;
      cfg_r.min_pulse <= MIN_RST;
      cfg_r.max_pulse <= MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEUTRAL: cfg_r.neutral   <= cfg_wdata;
        CFG_MIN:     cfg_r.min_pulse <= cfg_wdata;
        CFG_MAX:     cfg_r.max_pulse <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      up_r  <= in_up;
      dur_r <= in_duration_ms;
      pos_r <= in_position_us;
    end
  end

  stm_step u_step (
    .cfg         (cfg_r),
    .cur         (st_r),
    .action      (act_r),
    .up          (up_r),
    .duration_ms (dur_r),
    .position_us (pos_r),
    .nxt         (st_nxt),
    .res         (res_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase     <= PH_IDLE;
      st_r.remaining <= '0;
      st_r.pulse     <= '0;
      st_r.drive     <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_pulse_us = res_r.pulse_us;
  assign out_drive_on = res_r.drive_on;
  assign out_phase    = res_r.phase;
  assign out_stopped  = res_r.stopped;

  // Idle leaves no time on the countdown
  a_idle_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_IDLE |-> st_r.remaining == '0)
    else $error("idle phase with remaining time");

  // Any running sequence keeps the drive on
  a_busy_drive: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_IDLE |-> st_r.drive)
    else $error("sequence running with drive off");

  // A stop result always reports idle with drive off
  a_stop_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.stopped |-> !res_r.drive_on && res_r.phase == PHC_IDLE)
    else $error("stop result not idle");

  // Stalled output with a held item blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are full");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.phase))
    else $error("phase not one-hot");

endmodule
